// ===== hdl/tbdp_pkg.sv =====
package tbdp_pkg;

    // Chunk geometry
    localparam int MAX_CHUNKS     = 64;
    localparam int CHUNK_ELEMS    = 128;
    localparam int WORD_W         = 64;
    localparam int LANES          = 8;
    localparam int LANE_W         = CHUNK_ELEMS / LANES;
    localparam int NIBBLES        = LANE_W / 4;

    // Lane and chunk score widths (score = agreeing - disagreeing nonzero elements)
    localparam int LANE_CNT_W     = $clog2(LANE_W + 1);
    localparam int LANE_SCORE_W   = LANE_CNT_W + 1;
    localparam int CHUNK_SCORE_W  = $clog2(CHUNK_ELEMS + 1) + 1;

    // Running sum
    localparam int SUM_BOUND      = MAX_CHUNKS * CHUNK_ELEMS;
    localparam int SUM_W          = $clog2(SUM_BOUND + 1) + 1;

    // Activation
    localparam int SLOPE_W        = 16;
    localparam int FRAC_BITS      = 12;
    localparam int ACT_W          = 30;
    localparam int OUT_BOUND      = 2 ** (ACT_W - 2);
    localparam int PROD_W         = SUM_W + SLOPE_W;

    typedef logic [LANE_W-1:0]               lane_data_t;
    typedef logic [LANE_CNT_W-1:0]           lane_cnt_t;
    typedef logic signed [LANE_SCORE_W-1:0]  lane_score_t;
    typedef logic signed [CHUNK_SCORE_W-1:0] chunk_score_t;
    typedef logic signed [SUM_W-1:0]         sum_t;
    typedef logic signed [SLOPE_W-1:0]       slope_t;
    typedef logic signed [PROD_W-1:0]        prod_t;
    typedef logic signed [ACT_W-1:0]         act_t;

    // Closed dot product handed from the accumulator to the activation stage
    typedef struct packed {
        sum_t sum;
        logic sat;
    } acc_beat_t;

    // Count ones per nibble, then add the nibble counts
    function automatic lane_cnt_t lane_popcount(lane_data_t v);
        logic [2:0] nib [NIBBLES];
        lane_cnt_t  total;
        total = '0;
        for (int n = 0; n < NIBBLES; n++) begin
            nib[n] = 3'(v[4*n]) + 3'(v[4*n+1]) + 3'(v[4*n+2]) + 3'(v[4*n+3]);
        end
        for (int n = 0; n < NIBBLES; n++) begin
            total = total + LANE_CNT_W'(nib[n]);
        end
        return total;
    endfunction

    // Nonzero elements whose sign matches the weight count +1, others -1
    function automatic lane_score_t lane_score(lane_data_t sgn, lane_data_t msk,
                                               lane_data_t wgt);
        lane_data_t diff;
        lane_cnt_t  pos;
        lane_cnt_t  neg;
        diff = sgn ^ wgt;
        pos  = lane_popcount(msk & ~diff);
        neg  = lane_popcount(msk & diff);
        return $signed({1'b0, pos}) - $signed({1'b0, neg});
    endfunction

endpackage

// ===== hdl/tbdp_lane.sv =====
module tbdp_lane (
    input  logic                  clk,
    input  logic                  load,
    input  tbdp_pkg::lane_data_t  sign_bits,
    input  tbdp_pkg::lane_data_t  mask_bits,
    input  tbdp_pkg::lane_data_t  weight_bits,
    output tbdp_pkg::lane_score_t score
);

    tbdp_pkg::lane_score_t score_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            score_reg <= tbdp_pkg::lane_score(sign_bits, mask_bits, weight_bits);
        end
    end

    assign score = score_reg;

endmodule

// ===== hdl/tbdp_merge.sv =====
module tbdp_merge (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   in_final,
    input  tbdp_pkg::lane_score_t  lane_score [tbdp_pkg::LANES],
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_final,
    output tbdp_pkg::chunk_score_t out_score
);

    logic                   valid_reg;
    logic                   final_reg;
    tbdp_pkg::chunk_score_t score_reg;
    tbdp_pkg::chunk_score_t score_next;
    logic                   take;

    always_comb
    begin
        score_next = '0;
        for (int l = 0; l < tbdp_pkg::LANES; l++) begin
            score_next = score_next + tbdp_pkg::CHUNK_SCORE_W'(lane_score[l]);
        end
    end

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            final_reg <= in_final;
            score_reg <= score_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_final = final_reg;
    assign out_score = score_reg;

endmodule

// ===== hdl/tbdp_accum.sv =====
module tbdp_accum (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   in_final,
    input  tbdp_pkg::chunk_score_t in_score,
    output logic                   out_valid,
    input  logic                   out_ready,
    output tbdp_pkg::acc_beat_t    out_beat
);

    localparam int XW = tbdp_pkg::SUM_W + 1;

    tbdp_pkg::sum_t      running_sum_reg;
    tbdp_pkg::sum_t      running_sum_next;
    logic                sat_reg;
    logic                sat_next;
    logic                out_valid_reg;
    tbdp_pkg::acc_beat_t beat_reg;
    logic signed [XW-1:0] sum_x;
    logic                take;

    // Add the chunk score and clamp to the sum bound
    always_comb
    begin
        sum_x    = XW'(running_sum_reg) + XW'(in_score);
        sat_next = sat_reg;
        priority if (sum_x > XW'(tbdp_pkg::SUM_BOUND))
        begin
            running_sum_next = tbdp_pkg::SUM_W'(tbdp_pkg::SUM_BOUND);
            sat_next         = 1'b1;
        end
        else if (sum_x < -XW'(tbdp_pkg::SUM_BOUND))
        begin
            running_sum_next = -tbdp_pkg::SUM_W'(tbdp_pkg::SUM_BOUND);
            sat_next         = 1'b1;
        end
        else
        begin
            running_sum_next = tbdp_pkg::SUM_W'(sum_x);
        end
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg <= '0;
            sat_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (take && in_final)
            begin
                running_sum_reg <= '0;
                sat_reg         <= 1'b0;
                out_valid_reg   <= 1'b1;
            end
            else
            begin
                if (take)
                begin
                    running_sum_reg <= running_sum_next;
                    sat_reg         <= sat_next;
                end
                if (out_ready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_final)
        begin
            beat_reg.sum <= running_sum_next;
            beat_reg.sat <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = beat_reg;

    a_sum_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (running_sum_reg <= tbdp_pkg::SUM_W'(tbdp_pkg::SUM_BOUND)) &&
        (running_sum_reg >= -tbdp_pkg::SUM_W'(tbdp_pkg::SUM_BOUND)))
        else $error("running sum outside its bound");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (take && in_final) |=> (running_sum_reg == '0 && !sat_reg && out_valid_reg))
        else $error("final chunk did not close the dot product");

endmodule

// ===== hdl/tbdp_prelu.sv =====
module tbdp_prelu (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tbdp_pkg::acc_beat_t in_beat,
    input  tbdp_pkg::slope_t    slope,
    output logic                out_valid,
    input  logic                out_ready,
    output tbdp_pkg::act_t      activation,
    output logic                saturated
);

    localparam int PW = tbdp_pkg::PROD_W;

    logic            prod_valid_reg;
    tbdp_pkg::prod_t prod_reg;
    tbdp_pkg::prod_t prod_next;
    logic            prod_sat_reg;
    logic            prod_ready;
    logic            prod_take;

    logic            out_valid_reg;
    tbdp_pkg::act_t  act_reg;
    tbdp_pkg::act_t  act_next;
    logic            sat_out_reg;
    logic            sat_out_next;
    logic            out_take;

    // Positive sums scale by one in fixed point, the rest by the slope
    always_comb
    begin
        if (in_beat.sum > 0)
        begin
            prod_next = PW'(in_beat.sum) <<< tbdp_pkg::FRAC_BITS;
        end
        else
        begin
            prod_next = in_beat.sum * slope;
        end
    end

    // Clamp to the output range
    always_comb
    begin
        sat_out_next = prod_sat_reg;
        priority if (prod_reg > PW'(tbdp_pkg::OUT_BOUND))
        begin
            act_next     = tbdp_pkg::ACT_W'(tbdp_pkg::OUT_BOUND);
            sat_out_next = 1'b1;
        end
        else if (prod_reg < -PW'(tbdp_pkg::OUT_BOUND))
        begin
            act_next     = -tbdp_pkg::ACT_W'(tbdp_pkg::OUT_BOUND);
            sat_out_next = 1'b1;
        end
        else
        begin
            act_next = tbdp_pkg::ACT_W'(prod_reg);
        end
    end

    assign out_take   = prod_valid_reg && (!out_valid_reg || out_ready);
    assign prod_ready = !prod_valid_reg || out_take;
    assign prod_take  = in_valid && prod_ready;
    assign in_ready   = prod_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_take)
            begin
                prod_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                prod_valid_reg <= 1'b0;
            end
            if (out_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_take)
        begin
            prod_reg     <= prod_next;
            prod_sat_reg <= in_beat.sat;
        end
        if (out_take)
        begin
            act_reg     <= act_next;
            sat_out_reg <= sat_out_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign activation = act_reg;
    assign saturated  = sat_out_reg;

    a_act_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((act_reg <= tbdp_pkg::ACT_W'(tbdp_pkg::OUT_BOUND)) &&
                           (act_reg >= -tbdp_pkg::ACT_W'(tbdp_pkg::OUT_BOUND))))
        else $error("activation outside the output range");

endmodule

// ===== hdl/ternary_binary_dot_prelu.sv =====
// Channel | Handshake            | Payload
// --------+----------------------+------------------------------------------------
// in      | in_valid / in_ready  | sign/mask/weight words low+high, final_chunk
// out     | out_valid / out_ready| activation_out, saturated
// cfg     | cfg_write            | cfg_data (prelu_slope, Q4.12 signed)
//
// One chunk beat is taken per cycle with no gap while in_ready is high. A result
// beat is offered once its final chunk has passed through five registers; the
// edge that takes that chunk loads the first: lane popcount register, lane merge
// adder, running-sum accumulator, PReLU multiplier, output clamp register.
// The running-sum loop in the accumulator sets the sustained rate.
// Reset clears the running sum, the saturation flag, the slope and all valid
// bits; no clearing pass is needed. A stalled out beat holds every stage that
// is full; stages that are empty keep filling, so in_ready drops only once the
// pipeline is packed behind the held result.
module ternary_binary_dot_prelu (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tbdp_pkg::WORD_W-1:0] sign_word_low,
    input  logic [tbdp_pkg::WORD_W-1:0] sign_word_high,
    input  logic [tbdp_pkg::WORD_W-1:0] mask_word_low,
    input  logic [tbdp_pkg::WORD_W-1:0] mask_word_high,
    input  logic [tbdp_pkg::WORD_W-1:0] weight_word_low,
    input  logic [tbdp_pkg::WORD_W-1:0] weight_word_high,
    input  logic                        final_chunk,

    output logic                        out_valid,
    input  logic                        out_ready,
    output tbdp_pkg::act_t              activation_out,
    output logic                        saturated,

    input  logic                        cfg_write,
    input  tbdp_pkg::slope_t            cfg_data
);

    localparam int ALL_W = 2 * tbdp_pkg::WORD_W;

    // Slope register; the user must write it only while the block is idle, the block has no guard for it
    tbdp_pkg::slope_t       slope_reg;

    // Lane stage control: lanes hold their own score registers
    logic                   lane_valid_reg;
    logic                   lane_final_reg;
    logic                   lane_load;
    tbdp_pkg::lane_score_t  lane_score [tbdp_pkg::LANES];

    // Whole-chunk views of the words; lane l owns elements l*LANE_W upward
    logic [ALL_W-1:0]       sign_all;
    logic [ALL_W-1:0]       mask_all;
    logic [ALL_W-1:0]       weight_all;

    logic                   merge_ready;
    logic                   merge_valid;
    logic                   merge_final;
    tbdp_pkg::chunk_score_t merge_score;

    logic                   acc_ready;
    logic                   acc_valid;
    tbdp_pkg::acc_beat_t    acc_beat;

    logic                   act_ready;

    assign sign_all   = {sign_word_high, sign_word_low};
    assign mask_all   = {mask_word_high, mask_word_low};
    assign weight_all = {weight_word_high, weight_word_low};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_reg <= '0;
        end
        else if (cfg_write)
        begin
            slope_reg <= cfg_data;
        end
    end

    // Accept a chunk whenever the lane registers are empty or draining
    assign in_ready  = !lane_valid_reg || merge_ready;
    assign lane_load = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_valid_reg <= 1'b0;
        end
        else
        begin
            if (lane_load)
            begin
                lane_valid_reg <= 1'b1;
            end
            else if (merge_ready)
            begin
                lane_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (lane_load)
        begin
            lane_final_reg <= final_chunk;
        end
    end

    // Eight popcount lanes score sixteen elements each in parallel
    for (genvar l = 0; l < tbdp_pkg::LANES; l++) begin : g_lane
        tbdp_lane u_lane (
            .clk         (clk),
            .load        (lane_load),
            .sign_bits   (sign_all[l*tbdp_pkg::LANE_W +: tbdp_pkg::LANE_W]),
            .mask_bits   (mask_all[l*tbdp_pkg::LANE_W +: tbdp_pkg::LANE_W]),
            .weight_bits (weight_all[l*tbdp_pkg::LANE_W +: tbdp_pkg::LANE_W]),
            .score       (lane_score[l])
        );
    end

    // Merge the lane scores into one chunk score
    tbdp_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (lane_valid_reg),
        .in_ready   (merge_ready),
        .in_final   (lane_final_reg),
        .lane_score (lane_score),
        .out_valid  (merge_valid),
        .out_ready  (acc_ready),
        .out_final  (merge_final),
        .out_score  (merge_score)
    );

    // Accumulate chunks with saturation; emit a beat only on the final chunk
    tbdp_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (merge_valid),
        .in_ready  (acc_ready),
        .in_final  (merge_final),
        .in_score  (merge_score),
        .out_valid (acc_valid),
        .out_ready (act_ready),
        .out_beat  (acc_beat)
    );

    // PReLU multiply, clamp and output register
    tbdp_prelu u_prelu (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (acc_valid),
        .in_ready   (act_ready),
        .in_beat    (acc_beat),
        .slope      (slope_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .activation (activation_out),
        .saturated  (saturated)
    );

endmodule

// ===== tb/sv/ternary_binary_dot_prelu_tb.sv =====
module ternary_binary_dot_prelu_tb;

    // Abort well past the slowest legal run (about 1650 chunk beats, heavy
    // idling on both sides).
    localparam int CYCLE_LIMIT = 400000;
    // Cycles to hold after the last result so nonfinal beats clear the pipe.
    localparam int SETTLE_CYCLES = 10;

    localparam logic [tbdp_pkg::WORD_W-1:0] ALL_ONES = '1;
    localparam logic [tbdp_pkg::WORD_W-1:0] NO_BITS  = '0;

    // Content style of one dot product in the random part
    typedef enum int {
        MIX_RANDOM,
        MIX_AGREE,
        MIX_DISAGREE,
        MIX_SPARSE,
        MIX_LEAN_POS,
        MIX_LEAN_NEG
    } mix_t;

    typedef struct {
        logic [tbdp_pkg::WORD_W-1:0] sign_low;
        logic [tbdp_pkg::WORD_W-1:0] sign_high;
        logic [tbdp_pkg::WORD_W-1:0] mask_low;
        logic [tbdp_pkg::WORD_W-1:0] mask_high;
        logic [tbdp_pkg::WORD_W-1:0] weight_low;
        logic [tbdp_pkg::WORD_W-1:0] weight_high;
        logic                        last;
    } chunk_t;

    typedef struct {
        tbdp_pkg::act_t act;
        logic           sat;
    } activation_t;

    // Tracks the running dot product and holds the activations still owed.
    class dot_scoreboard;
        tbdp_pkg::slope_t slope;
        tbdp_pkg::sum_t   running_sum;
        logic             sat_flag;
        activation_t      owed_acts[$];
        int               errors;

        function new();
            slope       = '0;
            running_sum = '0;
            sat_flag    = 1'b0;
            errors      = 0;
        endfunction

        // Fold one accepted chunk beat into the sum; on a final beat queue
        // the PReLU output and clear the sum.
        function void note_chunk(chunk_t c);
            int          nonzero;
            int          against;
            int          next_sum;
            longint      act;
            activation_t a;
            nonzero  = $countones(c.mask_low) + $countones(c.mask_high);
            against  = $countones((c.sign_low ^ c.weight_low) & c.mask_low) +
                       $countones((c.sign_high ^ c.weight_high) & c.mask_high);
            next_sum = int'(running_sum) + nonzero - 2 * against;
            if (next_sum > tbdp_pkg::SUM_BOUND) begin
                next_sum = tbdp_pkg::SUM_BOUND;
                sat_flag = 1'b1;
            end
            else if (next_sum < -tbdp_pkg::SUM_BOUND) begin
                next_sum = -tbdp_pkg::SUM_BOUND;
                sat_flag = 1'b1;
            end
            running_sum = tbdp_pkg::sum_t'(next_sum);
            if (!c.last)
                return;
            // Zero takes the slope branch and so gives zero.
            if (next_sum > 0)
                act = longint'(next_sum) * (longint'(1) << tbdp_pkg::FRAC_BITS);
            else
                act = longint'(next_sum) * longint'(slope);
            a.sat = sat_flag;
            if (act > tbdp_pkg::OUT_BOUND) begin
                act   = tbdp_pkg::OUT_BOUND;
                a.sat = 1'b1;
            end
            else if (act < -tbdp_pkg::OUT_BOUND) begin
                act   = -tbdp_pkg::OUT_BOUND;
                a.sat = 1'b1;
            end
            a.act = tbdp_pkg::act_t'(act);
            owed_acts.push_back(a);
            running_sum = '0;
            sat_flag    = 1'b0;
        endfunction

        function void check_result(tbdp_pkg::act_t act, logic sat);
            activation_t a;
            if (owed_acts.size() == 0) begin
                errors++;
                $display("%0t: result beat with none expected: activation_out %0d saturated %0b",
                         $time, act, sat);
                return;
            end
            a = owed_acts.pop_front();
            if (act !== a.act) begin
                errors++;
                $display("%0t: activation_out expected %0d got %0d", $time, a.act, act);
            end
            if (sat !== a.sat) begin
                errors++;
                $display("%0t: saturated expected %0b got %0b", $time, a.sat, sat);
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [tbdp_pkg::WORD_W-1:0] sign_word_low;
    logic [tbdp_pkg::WORD_W-1:0] sign_word_high;
    logic [tbdp_pkg::WORD_W-1:0] mask_word_low;
    logic [tbdp_pkg::WORD_W-1:0] mask_word_high;
    logic [tbdp_pkg::WORD_W-1:0] weight_word_low;
    logic [tbdp_pkg::WORD_W-1:0] weight_word_high;
    logic                        final_chunk;
    logic                        out_valid;
    logic                        out_ready;
    tbdp_pkg::act_t              activation_out;
    logic                        saturated;
    logic                        cfg_write;
    tbdp_pkg::slope_t            cfg_data;

    dot_scoreboard sb = new();
    int            send_idle_pct;
    int            recv_stall_pct;
    int            cycles = 0;

    ternary_binary_dot_prelu dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .sign_word_low    (sign_word_low),
        .sign_word_high   (sign_word_high),
        .mask_word_low    (mask_word_low),
        .mask_word_high   (mask_word_high),
        .weight_word_low  (weight_word_low),
        .weight_word_high (weight_word_high),
        .final_chunk      (final_chunk),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .activation_out   (activation_out),
        .saturated        (saturated),
        .cfg_write        (cfg_write),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: decide ready at the falling edge, take the result beat at the
    // rising edge. Values read here are the ones from before the edge.
    always @(negedge clk)
    begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("ternary_binary_dot_prelu_tb: errors");
            $finish;
        end
        else if (rst_n && out_valid && out_ready) begin
            sb.check_result(activation_out, saturated);
        end
    end

    function automatic logic [tbdp_pkg::WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Build a chunk whose content leans the way the style asks.
    function automatic chunk_t make_chunk(mix_t mix, logic last);
        chunk_t c;
        c.sign_low    = rand_word();
        c.sign_high   = rand_word();
        c.mask_low    = rand_word();
        c.mask_high   = rand_word();
        c.weight_low  = rand_word();
        c.weight_high = rand_word();
        c.last        = last;
        case (mix)
            MIX_AGREE: begin
                c.mask_low    = ALL_ONES;
                c.mask_high   = ALL_ONES;
                c.weight_low  = c.sign_low;
                c.weight_high = c.sign_high;
            end
            MIX_DISAGREE: begin
                c.mask_low    = ALL_ONES;
                c.mask_high   = ALL_ONES;
                c.weight_low  = ~c.sign_low;
                c.weight_high = ~c.sign_high;
            end
            MIX_SPARSE: begin
                c.mask_low  = c.mask_low & rand_word() & rand_word();
                c.mask_high = c.mask_high & rand_word() & rand_word();
            end
            MIX_LEAN_POS: begin
                c.mask_low    = c.mask_low | rand_word();
                c.mask_high   = c.mask_high | rand_word();
                c.weight_low  = c.sign_low ^ (rand_word() & rand_word() & rand_word());
                c.weight_high = c.sign_high ^ (rand_word() & rand_word() & rand_word());
            end
            MIX_LEAN_NEG: begin
                c.mask_low    = c.mask_low | rand_word();
                c.mask_high   = c.mask_high | rand_word();
                c.weight_low  = ~c.sign_low ^ (rand_word() & rand_word() & rand_word());
                c.weight_high = ~c.sign_high ^ (rand_word() & rand_word() & rand_word());
            end
            default: ;
        endcase
        return c;
    endfunction

    // Present one chunk beat: idle at random first, then hold valid and the
    // payload until the beat is taken. Call and return at a falling edge.
    task automatic send_chunk(chunk_t c);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid         = 1'b1;
        sign_word_low    = c.sign_low;
        sign_word_high   = c.sign_high;
        mask_word_low    = c.mask_low;
        mask_word_high   = c.mask_high;
        weight_word_low  = c.weight_low;
        weight_word_high = c.weight_high;
        final_chunk      = c.last;
        do @(posedge clk); while (!in_ready);
        sb.note_chunk(c);
        @(negedge clk);
    endtask

    task automatic send_dot(mix_t mix, int length);
        for (int i = 0; i < length; i++) begin
            send_chunk(make_chunk(mix, i == length - 1));
        end
    endtask

    // Drop valid and wait out every owed result, then let trailing
    // nonfinal beats drain through the pipe.
    task automatic drain();
        in_valid = 1'b0;
        while (sb.owed_acts.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write the slope only with the block idle.
    task automatic set_slope(tbdp_pkg::slope_t value);
        drain();
        cfg_data  = value;
        cfg_write = 1'b1;
        @(negedge clk);
        cfg_write = 1'b0;
        sb.slope  = value;
    endtask

    // One random phase: dot products of mostly short length, a few long
    // ones that can run into the sum bound. Each phase ends on a final beat.
    task automatic run_phase(tbdp_pkg::slope_t slope, int send_pct, int recv_pct,
                             int beats);
        int   sent;
        int   pick;
        int   length;
        mix_t mix;
        set_slope(slope);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < beats) begin
            pick = $urandom_range(99);
            if (pick < 80)
                length = $urandom_range(1, 8);
            else if (pick < 95)
                length = $urandom_range(9, 40);
            else
                length = $urandom_range(60, 72);
            mix = mix_t'($urandom_range(MIX_LEAN_NEG, MIX_RANDOM));
            send_dot(mix, length);
            sent += length;
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        sign_word_low    = '0;
        sign_word_high   = '0;
        mask_word_low    = '0;
        mask_word_high   = '0;
        weight_word_low  = '0;
        weight_word_high = '0;
        final_chunk      = 1'b0;
        cfg_write        = 1'b0;
        cfg_data         = '0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset slope of zero, full agreement and full disagreement,
        // an empty mask (zero sum), halves that cancel, a single element.
        send_chunk('{ALL_ONES, NO_BITS, ALL_ONES, ALL_ONES, ALL_ONES, NO_BITS, 1'b1});
        send_chunk('{ALL_ONES, ALL_ONES, NO_BITS, NO_BITS, NO_BITS, NO_BITS, 1'b1});
        send_chunk('{ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, NO_BITS, NO_BITS, 1'b1});
        set_slope(tbdp_pkg::slope_t'(-32768));
        send_chunk('{NO_BITS, NO_BITS, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1});
        send_chunk('{NO_BITS, ALL_ONES, NO_BITS, ALL_ONES, ALL_ONES, ALL_ONES, 1'b0});
        send_chunk('{ALL_ONES, NO_BITS, ALL_ONES, NO_BITS, NO_BITS, NO_BITS, 1'b1});
        send_chunk('{64'h8000_0000_0000_0000, NO_BITS, 64'h8000_0000_0000_0000, NO_BITS,
                     NO_BITS, NO_BITS, 1'b1});
        send_chunk('{NO_BITS, NO_BITS, NO_BITS, 64'h1, NO_BITS, NO_BITS, 1'b1});
        set_slope(tbdp_pkg::slope_t'(32767));
        send_chunk('{NO_BITS, NO_BITS, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1});
        send_chunk('{ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b0});
        send_chunk('{NO_BITS, NO_BITS, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1});
        send_chunk(make_chunk(MIX_RANDOM, 1'b1));
        send_chunk(make_chunk(MIX_SPARSE, 1'b1));

        // Sum bound: exactly at the bound (no saturation), then past it both
        // ways, with the extreme slopes on the negative side.
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        send_dot(MIX_AGREE, 64);
        send_dot(MIX_AGREE, 70);
        send_dot(MIX_DISAGREE, 64);
        send_dot(MIX_DISAGREE, 68);
        set_slope(tbdp_pkg::slope_t'(-32768));
        send_dot(MIX_DISAGREE, 66);

        // Random phases; every phase boundary also stalls the sender until
        // every owed result has come back.
        run_phase(tbdp_pkg::slope_t'(32767), 0, 0, 150);
        run_phase(tbdp_pkg::slope_t'(-32768), 76, 0, 150);
        run_phase(tbdp_pkg::slope_t'(0), 0, 76, 150);
        run_phase(tbdp_pkg::slope_t'(4096), 28, 28, 150);
        run_phase(tbdp_pkg::slope_t'($urandom_range(65535)), 0, 0, 150);
        run_phase(tbdp_pkg::slope_t'(-1), 76, 0, 150);
        run_phase(tbdp_pkg::slope_t'($urandom_range(65535)), 0, 76, 150);
        run_phase(tbdp_pkg::slope_t'(1), 28, 28, 150);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.owed_acts.size() == 0) begin
            $display("ternary_binary_dot_prelu_tb: clean");
        end
        else begin
            $display("ternary_binary_dot_prelu_tb: errors");
        end
        $finish;
    end

endmodule
